/* rtl/ptnp_pkg.sv */
package ptnp_pkg;

    // Number width of the search; values are masked to it.
    localparam int WIDTH = 32;
    // Width of the value and prime_found fields.
    localparam int NUM_W = 32;
    // Trial divisor and its square.
    localparam int DIV_W = NUM_W / 2 + 1;
    localparam int SQ_W  = 2 * DIV_W;
    // Bit counter of the serial remainder unit.
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [NUM_W-1:0] VALUE_MASK =
        (WIDTH >= NUM_W) ? {NUM_W{1'b1}} : NUM_W'((64'd1 << WIDTH) - 64'd1);
    localparam logic [NUM_W-1:0] LIMIT      = VALUE_MASK;
    localparam logic [NUM_W-1:0] LIMIT_M2   = LIMIT - NUM_W'(2);

    localparam logic KIND_TEST = 1'b0;
    localparam logic KIND_NEXT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOOP,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

/* rtl/prime_test_and_next_prime.sv */
// Channel   | handshake          | payload
// ----------+--------------------+---------------------------------------
// request   | in_valid/in_ready  | kind (1), value (32)
// result    | out_valid/out_ready| is_prime (1), prime_found (32), overflow (1)
//
// One request at a time. Each trial division loads the bit-serial
// remainder unit in ST_LOOP and then runs it over every bit of the
// candidate in ST_DIV; a next-prime search repeats the test per candidate.
// rst_n clears the sequencer and the result valid. A stalled result waits in
// the output register; the next request is taken while it waits.
module prime_test_and_next_prime
    import ptnp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [NUM_W-1:0] value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             is_prime,
    output logic [NUM_W-1:0] prime_found,
    output logic             overflow
);

    state_t state_reg, state_next;

    // Request and search datapath
    logic             kind_reg,  kind_next;
    logic [NUM_W-1:0] cand_reg,  cand_next;
    logic [DIV_W-1:0] d_reg,     d_next;
    logic [SQ_W-1:0]  sq_reg,    sq_next;
    // Serial remainder unit: shifting copy of the candidate and partial remainder
    logic [NUM_W-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0] rem_reg,   rem_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    // Pending result, moved to the output register in ST_FINISH
    logic             res_prime_reg, res_prime_next;
    logic [NUM_W-1:0] res_found_reg, res_found_next;
    logic             res_ovf_reg,   res_ovf_next;
    // Output register
    logic             out_valid_reg;
    logic             is_prime_reg;
    logic [NUM_W-1:0] prime_found_reg;
    logic             overflow_reg;

    logic             in_xfer;
    logic             out_free;
    logic [NUM_W-1:0] value_m;
    logic [DIV_W:0]   trial;
    logic             trial_ge;
    logic             div_last;
    logic             rem_zero;
    logic             sq_over;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign value_m   = value & VALUE_MASK;

    // One restoring remainder step per cycle.
    assign trial     = {rem_reg, shift_reg[NUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, d_reg});
    assign div_last  = (cnt_reg == CNT_W'(NUM_W - 1));
    assign rem_zero  = trial_ge ? (trial == {1'b0, d_reg}) : (trial == '0);
    assign sq_over   = (sq_reg > SQ_W'(cand_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == KIND_TEST)
                        state_next = ST_START;
                    else if (value_m <= NUM_W'(2) || (value_m[0] && value_m > LIMIT_M2))
                        state_next = ST_FINISH;
                    else
                        state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (cand_reg < NUM_W'(2) || !cand_reg[0])
                    state_next = ST_FINISH;
                else
                    state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (sq_over)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    if (!rem_zero)
                        state_next = ST_LOOP;
                    else if (kind_reg == KIND_TEST || cand_reg > LIMIT_M2)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_START;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        kind_next      = kind_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        shift_next     = shift_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_prime_next = res_prime_reg;
        res_found_next = res_found_reg;
        res_ovf_next   = res_ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_next      = kind;
                    res_prime_next = 1'b0;
                    res_found_next = '0;
                    res_ovf_next   = 1'b0;
                    if (kind == KIND_TEST)
                        cand_next = value_m;
                    else if (value_m <= NUM_W'(2))
                    begin
                        // Small values give two directly.
                        res_prime_next = 1'b1;
                        res_found_next = NUM_W'(2);
                    end
                    else if (!value_m[0])
                        cand_next = value_m + NUM_W'(1);
                    else if (value_m > LIMIT_M2)
                        res_ovf_next = 1'b1;
                    else
                        cand_next = value_m + NUM_W'(2);
                end
            end
            ST_START:
            begin
                // Even candidates only reach here from a primality test.
                if (cand_reg < NUM_W'(2))
                    res_prime_next = 1'b0;
                else if (!cand_reg[0])
                    res_prime_next = (cand_reg == NUM_W'(2));
                d_next  = DIV_W'(3);
                sq_next = SQ_W'(9);
            end
            ST_LOOP:
            begin
                if (sq_over)
                begin
                    // No divisor up to the square root: prime.
                    res_prime_next = 1'b1;
                    if (kind_reg == KIND_NEXT)
                        res_found_next = cand_reg;
                end
                else
                begin
                    shift_next = cand_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                shift_next = {shift_reg[NUM_W-2:0], 1'b0};
                rem_next   = trial_ge ? DIV_W'(trial - {1'b0, d_reg}) : DIV_W'(trial);
                cnt_next   = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    if (!rem_zero)
                    begin
                        // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
                        d_next  = d_reg + DIV_W'(2);
                        sq_next = sq_reg + SQ_W'({d_reg, 2'b00}) + SQ_W'(4);
                    end
                    else if (kind_reg == KIND_TEST)
                        res_prime_next = 1'b0;
                    else if (cand_reg > LIMIT_M2)
                    begin
                        res_prime_next = 1'b0;
                        res_found_next = '0;
                        res_ovf_next   = 1'b1;
                    end
                    else
                        cand_next = cand_reg + NUM_W'(2);
                end
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        cand_reg      <= cand_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        shift_reg     <= shift_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        res_prime_reg <= res_prime_next;
        res_found_reg <= res_found_next;
        res_ovf_reg   <= res_ovf_next;
        // Load the output register when the previous result is gone.
        if (state_reg == ST_FINISH && out_free)
        begin
            is_prime_reg    <= res_prime_reg;
            prime_found_reg <= res_found_reg;
            overflow_reg    <= res_ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_prime    = is_prime_reg;
    assign prime_found = prime_found_reg;
    assign overflow    = overflow_reg;

endmodule

/* tb/tb_prime_test_and_next_prime.sv */
module tb_prime_test_and_next_prime;
    import ptnp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Idle cycles allowed with no transfer on either channel. The slowest
    // request sent here is a 16-bit next-prime search; this leaves a wide
    // margin over it plus output stalls.
    localparam int WATCHDOG_LIMIT = 500_000;
    // Quiet cycles after the last result to catch a stray transfer.
    localparam int DRAIN_CYCLES   = 200;
    // Chance, in percent, that a side idles in a given cycle.
    localparam int IDLE_PCT       = 7;

    // One expected result transfer.
    typedef struct packed {
        logic             is_prime;
        logic [NUM_W-1:0] prime_found;
        logic             overflow;
    } prime_answer_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             kind = KIND_TEST;
    logic [NUM_W-1:0] value = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             is_prime;
    logic [NUM_W-1:0] prime_found;
    logic             overflow;

    // Answers for accepted requests, oldest first.
    prime_answer_t pending_answers[$];
    int            mismatch_count = 0;
    int            stalled_cycles = 0;
    // Suppress random idling on both channels while set.
    bit            quiet = 1'b0;

    prime_test_and_next_prime u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_prime    (is_prime),
        .prime_found (prime_found),
        .overflow    (overflow)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Odd trial division up to the square root; 2 is the only even prime.
    function automatic logic passes_trial_division(input logic [63:0] n);
        logic [63:0] d;
        if (n < 64'd2)
            return 1'b0;
        if (!n[0])
            return n == 64'd2;
        for (d = 64'd3; d <= n / d; d += 64'd2)
            if (n % d == 64'd0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Work out the result transfer for one request.
    function automatic prime_answer_t predict_answer(input logic k,
                                                     input logic [NUM_W-1:0] v);
        logic [63:0]   n;
        logic [63:0]   lim;
        logic [63:0]   cand;
        prime_answer_t ans;
        n   = 64'(v & VALUE_MASK);
        lim = 64'(LIMIT);
        ans = '0;
        if (k == KIND_TEST)
        begin
            ans.is_prime = passes_trial_division(n);
            return ans;
        end
        // Anything up to two gives two, two included.
        if (n <= 64'd2)
        begin
            ans.is_prime    = 1'b1;
            ans.prime_found = NUM_W'(2);
            return ans;
        end
        // Default to the overflow answer; replace it once a prime turns up.
        ans.overflow = 1'b1;
        if (!n[0])
            cand = n + 64'd1;
        else if (n > lim - 64'd2)
            return ans;
        else
            cand = n + 64'd2;
        while (!passes_trial_division(cand))
        begin
            if (cand > lim - 64'd2)
                return ans;
            cand += 64'd2;
        end
        ans.is_prime    = 1'b1;
        ans.prime_found = cand[NUM_W-1:0];
        ans.overflow    = 1'b0;
        return ans;
    endfunction

    // Stall the result channel at random, except in quiet stretches.
    always @(posedge clk)
    begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each result transfer against the oldest pending answer.
    always @(posedge clk)
    begin
        prime_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual %b/%h/%b",
                         $realtime, is_prime, prime_found, overflow);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (is_prime !== want.is_prime)
                begin
                    mismatch_count++;
                    $display("%0t: is_prime expected %b actual %b",
                             $realtime, want.is_prime, is_prime);
                end
                if (prime_found !== want.prime_found)
                begin
                    mismatch_count++;
                    $display("%0t: prime_found expected %h actual %h",
                             $realtime, want.prime_found, prime_found);
                end
                if (overflow !== want.overflow)
                begin
                    mismatch_count++;
                    $display("%0t: overflow expected %b actual %b",
                             $realtime, want.overflow, overflow);
                end
            end
        end
    end

    // End the run if neither channel transfers for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, stalled_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Send one request: idle at random, then hold valid and payload until
    // the transfer. Call at a rising edge; returns at the accepting edge
    // with valid still high, so the next call either drops it or reloads.
    task automatic send_request(input logic k, input logic [NUM_W-1:0] v);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_answers.push_back(predict_answer(k, v));
    endtask

    // Primality test at the field extremes, small primes, squares and evens.
    task automatic test_primality_edges();
        send_request(KIND_TEST, 32'd0);
        send_request(KIND_TEST, 32'd1);
        send_request(KIND_TEST, 32'd2);
        send_request(KIND_TEST, 32'd3);
        send_request(KIND_TEST, 32'd4);
        send_request(KIND_TEST, 32'd9);
        send_request(KIND_TEST, 32'd25);
        send_request(KIND_TEST, 32'd97);
        send_request(KIND_TEST, 32'd65521);
        send_request(KIND_TEST, 32'h8000_0000);
        send_request(KIND_TEST, 32'hFFFF_FFFE);
        send_request(KIND_TEST, 32'hFFFF_FFFF);
    endtask

    // Next prime: values up to two give two; odd and even starts; a gap.
    task automatic test_next_prime_edges();
        send_request(KIND_NEXT, 32'd0);
        send_request(KIND_NEXT, 32'd1);
        send_request(KIND_NEXT, 32'd2);
        send_request(KIND_NEXT, 32'd3);
        send_request(KIND_NEXT, 32'd7);
        send_request(KIND_NEXT, 32'd8);
        send_request(KIND_NEXT, 32'd23);
        send_request(KIND_NEXT, 32'd65521);
    endtask

    // Searches that run off the top of the width.
    task automatic test_search_overflow();
        send_request(KIND_NEXT, 32'hFFFF_FFFD);
        send_request(KIND_NEXT, 32'hFFFF_FFFE);
        send_request(KIND_NEXT, 32'hFFFF_FFFF);
    endtask

    // Small requests with no idling on either side.
    task automatic test_back_to_back(input int count);
        quiet = 1'b1;
        repeat (count)
            send_request(logic'($urandom_range(0, 1)), $urandom_range(0, 255));
        quiet = 1'b0;
    endtask

    // Random mix. Keep searches on small values so each stays cheap; reach
    // the high bits through tests of composites with a factor of 2 or 3
    // and through searches that start at the very top.
    task automatic test_random_mix(input int count);
        int               roll;
        logic [NUM_W-1:0] v;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                send_request(logic'($urandom_range(0, 1)), $urandom_range(0, 15));
            else if (roll < 60)
                send_request(logic'($urandom_range(0, 1)), $urandom_range(16, 4095));
            else if (roll < 78)
                send_request(logic'($urandom_range(0, 1)), $urandom_range(4096, 65535));
            else if (roll < 95)
            begin
                // Force an even value or a multiple of three.
                v = $urandom;
                if (v[0])
                    v = v - (v % 3);
                send_request(KIND_TEST, v);
            end
            else
                send_request(KIND_NEXT, 32'hFFFF_FFFF - $urandom_range(0, 2));
        end
    endtask

    initial
    begin
        // Hold reset low, then release it on a clock edge.
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_primality_edges();
        test_next_prime_edges();
        test_search_overflow();
        test_back_to_back(20);
        test_random_mix(57);

        // Drop valid after the last transfer and drain the results.
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
